@@ rtl/eerm_pkg.sv @@
// Shared types, widths and constants of the EWMA event rate meter.
// Depends on nothing; every other file of the block imports it.
package eerm_pkg;

    localparam int COUNT_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;

    localparam int EVENT_W     = 8;
    localparam int ALPHA_W     = 16;
    localparam int RATE_W      = 48;
    localparam int CFG_INDEX_W = 8;
    localparam int INV_FRAC    = 16;

    localparam int PROD_W    = RATE_W + ALPHA_W;
    localparam int MUL_STEPS = RATE_W / ALPHA_W;
    localparam int STEP_W    = $clog2(MUL_STEPS);
    localparam int NUM_RATES = 3;
    localparam int SEL_W     = $clog2(NUM_RATES);

    localparam int SCALE_UP = (FRACTION_BITS >= INV_FRAC) ? FRACTION_BITS - INV_FRAC : 0;
    localparam int SCALE_DN = (FRACTION_BITS < INV_FRAC) ? INV_FRAC - FRACTION_BITS : 0;
    localparam int EXT_W    = PROD_W + 8;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE_RESET     = ALPHA_W'(5240);
    localparam logic [ALPHA_W-1:0] ALPHA_FIVE_RESET    = ALPHA_W'(1083);
    localparam logic [ALPHA_W-1:0] ALPHA_FIFTEEN_RESET = ALPHA_W'(363);
    localparam logic [ALPHA_W-1:0] INV_INTERVAL_RESET  = ALPHA_W'(13107);
    localparam logic [PROD_W:0]    ROUND_UP            = (PROD_W + 1)'((1 << ALPHA_W) - 1);
    localparam logic [SEL_W-1:0]   LAST_RATE           = SEL_W'(NUM_RATES - 1);
    localparam logic [SEL_W-1:0]   SEL_ONE             = SEL_W'(0);
    localparam logic [SEL_W-1:0]   SEL_FIVE            = SEL_W'(1);
    localparam logic [SEL_W-1:0]   SEL_FIFTEEN         = SEL_W'(2);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALPHA_ONE     = CFG_INDEX_W'(0),
        REG_ALPHA_FIVE    = CFG_INDEX_W'(1),
        REG_ALPHA_FIFTEEN = CFG_INDEX_W'(2),
        REG_INV_INTERVAL  = CFG_INDEX_W'(3)
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INST_GO,
        ST_INST_WAIT,
        ST_DIFF,
        ST_SMOOTH_WAIT,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic item_valid;
        logic item_tick;
        logic mul_done;
        logic primed;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic             idle;
        logic             mul_start;
        logic             mul_instant;
        logic             take_instant;
        logic             take_rate;
        logic             publish;
        logic [SEL_W-1:0] sel;
    } ctrl_t;

    // Brings the Q.16 count product to the rate format and saturates it.
    function automatic logic [RATE_W-1:0] scale_instant(input logic [PROD_W-1:0] prod);
        logic [EXT_W-1:0] ext;
        ext = (EXT_W'(prod) << SCALE_UP) >> SCALE_DN;
        if (ext[EXT_W-1:RATE_W] != '0)
        begin
            return '1;
        end
        return ext[RATE_W-1:0];
    endfunction

endpackage

@@ rtl/eerm_channels.sv @@
// Handshake channel interfaces of the EWMA event rate meter: items in, rates out, config.
// Depends on eerm_pkg for the field widths.
interface eerm_in_if;
    import eerm_pkg::*;
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_count;
    logic               interval_tick;

    modport source (output valid, output event_count, output interval_tick, input ready);
    modport sink (input valid, input event_count, input interval_tick, output ready);
endinterface

interface eerm_out_if;
    import eerm_pkg::*;
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] one_minute_rate;
    logic [RATE_W-1:0] five_minute_rate;
    logic [RATE_W-1:0] fifteen_minute_rate;
    logic              rates_valid;

    modport source (output valid, output one_minute_rate, output five_minute_rate,
                    output fifteen_minute_rate, output rates_valid, input ready);
    modport sink (input valid, input one_minute_rate, input five_minute_rate,
                  input fifteen_minute_rate, input rates_valid, output ready);
endinterface

interface eerm_cfg_if;
    import eerm_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [ALPHA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/eerm_mul.sv @@
// Shared iterative multiplier: 16-bit factor times 48-bit factor, one 16-bit chunk per cycle.
// Depends on eerm_pkg for widths.
module eerm_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [eerm_pkg::ALPHA_W-1:0]    a,
    input  logic [eerm_pkg::RATE_W-1:0]     b,
    output logic                            done,
    output logic [eerm_pkg::PROD_W-1:0]     product
);
    import eerm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic [ALPHA_W-1:0]   a_reg, a_next;
    logic [RATE_W-1:0]    b_reg, b_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [2*ALPHA_W-1:0] partial;

    assign partial = (2 * ALPHA_W)'(a_reg) * (2 * ALPHA_W)'(b_reg[RATE_W-1 -: ALPHA_W]);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(MUL_STEPS - 1);
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg << ALPHA_W) + PROD_W'(partial);
            b_next   = b_reg << ALPHA_W;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/eerm_ctrl.sv @@
// Sequencer of the rate meter: walks one interval update through the shared multiplier.
// Depends on eerm_pkg for the state, status and control types.
module eerm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  eerm_pkg::stat_t stat,
    output eerm_pkg::ctrl_t ctrl
);
    import eerm_pkg::*;

    state_t           state_reg, state_next;
    logic [SEL_W-1:0] sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        sel_next          = sel_reg;
        ctrl              = '0;
        ctrl.sel          = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.idle = 1'b1;
                if (stat.item_valid)
                begin
                    if (stat.item_tick)
                    begin
                        state_next = ST_INST_GO;
                    end
                    else if (stat.out_free)
                    begin
                        ctrl.publish = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_PUBLISH;
                    end
                end
            end
            ST_INST_GO:
            begin
                ctrl.mul_start   = 1'b1;
                ctrl.mul_instant = 1'b1;
                state_next       = ST_INST_WAIT;
            end
            ST_INST_WAIT:
            begin
                if (stat.mul_done)
                begin
                    ctrl.take_instant = 1'b1;
                    if (stat.primed)
                    begin
                        sel_next   = SEL_ONE;
                        state_next = ST_DIFF;
                    end
                    else
                    begin
                        state_next = ST_PUBLISH;
                    end
                end
            end
            ST_DIFF:
            begin
                ctrl.mul_start = 1'b1;
                state_next     = ST_SMOOTH_WAIT;
            end
            ST_SMOOTH_WAIT:
            begin
                if (stat.mul_done)
                begin
                    ctrl.take_rate = 1'b1;
                    if (sel_reg == LAST_RATE)
                    begin
                        state_next = ST_PUBLISH;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_PUBLISH:
            begin
                if (stat.out_free)
                begin
                    ctrl.publish = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ewma_event_rate_meter.sv @@
// Top level of the EWMA event rate meter: config registers, counters, rates and output beat.
// Depends on eerm_pkg, the channel interfaces, eerm_ctrl and eerm_mul.
//
// Every accepted item adds its events to a saturating pending count and yields one output
// beat with the one, five and fifteen minute rates after that item. An item without an
// interval tick is published from idle while the output register is free or drained in the
// same cycle. An item with a tick runs through the shared 16 by 48 bit multiplier, once for
// the instant rate and once per smoothed rate, and no new item is taken until its beat is
// published; the first interval only loads the instant rate. The configuration channel is
// always ready.
module ewma_event_rate_meter (
    input  logic              clk,
    input  logic              rst_n,
    eerm_in_if.sink           items,
    eerm_out_if.source        rates,
    eerm_cfg_if.sink          cfg
);
    import eerm_pkg::*;

    logic [ALPHA_W-1:0]     alpha_one_reg, alpha_five_reg, alpha_fifteen_reg, inv_reg;
    logic [COUNT_WIDTH-1:0] pending_reg, pending_next;
    logic [RATE_W-1:0]      rate_one_reg, rate_one_next;
    logic [RATE_W-1:0]      rate_five_reg, rate_five_next;
    logic [RATE_W-1:0]      rate_fifteen_reg, rate_fifteen_next;
    logic                   primed_reg, primed_next;
    logic [RATE_W-1:0]      instant_reg, instant_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]      out_one_reg, out_five_reg, out_fifteen_reg;
    logic                   out_primed_reg;

    stat_t                  stat;
    ctrl_t                  ctrl;
    logic                   accept;
    logic [COUNT_WIDTH:0]   pending_sum;
    logic [RATE_W-1:0]      rate_cur, rate_upd, diff;
    logic [ALPHA_W-1:0]     alpha_cur, mul_a;
    logic [RATE_W-1:0]      mul_b;
    logic                   inst_ge;
    logic                   mul_done;
    logic [PROD_W-1:0]      product;
    logic [PROD_W:0]        product_round;

    assign accept        = items.valid && ctrl.idle;
    assign items.ready   = ctrl.idle;
    assign cfg.ready     = 1'b1;

    assign stat.item_valid = items.valid;
    assign stat.item_tick  = items.interval_tick;
    assign stat.mul_done   = mul_done;
    assign stat.primed     = primed_reg;
    assign stat.out_free   = !out_valid_reg || rates.ready;

    eerm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    eerm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctrl.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (product)
    );

    always_comb
    begin
        case (ctrl.sel)
            SEL_ONE:
            begin
                rate_cur  = rate_one_reg;
                alpha_cur = alpha_one_reg;
            end
            SEL_FIVE:
            begin
                rate_cur  = rate_five_reg;
                alpha_cur = alpha_five_reg;
            end
            SEL_FIFTEEN:
            begin
                rate_cur  = rate_fifteen_reg;
                alpha_cur = alpha_fifteen_reg;
            end
            default:
            begin
                rate_cur  = rate_one_reg;
                alpha_cur = alpha_one_reg;
            end
        endcase
    end

    assign inst_ge       = instant_reg >= rate_cur;
    assign diff          = inst_ge ? instant_reg - rate_cur : rate_cur - instant_reg;
    assign mul_a         = ctrl.mul_instant ? inv_reg : alpha_cur;
    assign mul_b         = ctrl.mul_instant ? RATE_W'(pending_reg) : diff;
    assign product_round = (PROD_W + 1)'(product) + ROUND_UP;
    assign rate_upd      = neg_reg ? rate_cur - RATE_W'(product_round >> ALPHA_W)
                                   : rate_cur + RATE_W'(product >> ALPHA_W);
    assign pending_sum   = (COUNT_WIDTH + 1)'(pending_reg)
                         + (COUNT_WIDTH + 1)'(items.event_count);

    always_comb
    begin
        pending_next      = pending_reg;
        rate_one_next     = rate_one_reg;
        rate_five_next    = rate_five_reg;
        rate_fifteen_next = rate_fifteen_reg;
        primed_next       = primed_reg;
        instant_next      = instant_reg;
        neg_next          = neg_reg;
        out_valid_next    = out_valid_reg && !rates.ready;

        if (accept)
        begin
            pending_next = pending_sum[COUNT_WIDTH] ? '1 : pending_sum[COUNT_WIDTH-1:0];
        end
        if (ctrl.mul_start && !ctrl.mul_instant)
        begin
            neg_next = !inst_ge;
        end
        if (ctrl.take_instant)
        begin
            instant_next = scale_instant(product);
            pending_next = '0;
            if (!primed_reg)
            begin
                rate_one_next     = scale_instant(product);
                rate_five_next    = scale_instant(product);
                rate_fifteen_next = scale_instant(product);
                primed_next       = 1'b1;
            end
        end
        if (ctrl.take_rate)
        begin
            case (ctrl.sel)
                SEL_ONE:     rate_one_next     = rate_upd;
                SEL_FIVE:    rate_five_next    = rate_upd;
                SEL_FIFTEEN: rate_fifteen_next = rate_upd;
                default:     rate_one_next     = rate_one_reg;
            endcase
        end
        if (ctrl.publish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_one_reg     <= ALPHA_ONE_RESET;
            alpha_five_reg    <= ALPHA_FIVE_RESET;
            alpha_fifteen_reg <= ALPHA_FIFTEEN_RESET;
            inv_reg           <= INV_INTERVAL_RESET;
            pending_reg       <= '0;
            rate_one_reg      <= '0;
            rate_five_reg     <= '0;
            rate_fifteen_reg  <= '0;
            primed_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_ALPHA_ONE:     alpha_one_reg     <= cfg.data;
                    REG_ALPHA_FIVE:    alpha_five_reg    <= cfg.data;
                    REG_ALPHA_FIFTEEN: alpha_fifteen_reg <= cfg.data;
                    REG_INV_INTERVAL:  inv_reg           <= cfg.data;
                    default:           inv_reg           <= inv_reg;
                endcase
            end
            pending_reg      <= pending_next;
            rate_one_reg     <= rate_one_next;
            rate_five_reg    <= rate_five_next;
            rate_fifteen_reg <= rate_fifteen_next;
            primed_reg       <= primed_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        instant_reg <= instant_next;
        neg_reg     <= neg_next;
        if (ctrl.publish)
        begin
            out_one_reg     <= rate_one_reg;
            out_five_reg    <= rate_five_reg;
            out_fifteen_reg <= rate_fifteen_reg;
            out_primed_reg  <= primed_reg;
        end
    end

    assign rates.valid               = out_valid_reg;
    assign rates.one_minute_rate     = out_one_reg;
    assign rates.five_minute_rate    = out_five_reg;
    assign rates.fifteen_minute_rate = out_fifteen_reg;
    assign rates.rates_valid         = out_primed_reg;

endmodule

@@ rtl/eerm_checker.sv @@
// Port-level checks of the EWMA event rate meter, bound to the top level.
// Depends on eerm_pkg for the rate width.
module eerm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [eerm_pkg::RATE_W-1:0] one_rate,
    input logic [eerm_pkg::RATE_W-1:0] five_rate,
    input logic [eerm_pkg::RATE_W-1:0] fifteen_rate,
    input logic                        rates_valid
);
    import eerm_pkg::*;

    logic seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (out_valid && out_ready && rates_valid)
        begin
            seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(one_rate) && $stable(five_rate)
            && $stable(fifteen_rate) && $stable(rates_valid))
        else $error("Output beat changed while stalled.");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg |-> rates_valid)
        else $error("Rates fell back to not valid after the first interval.");

    a_zero_before_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rates_valid |-> one_rate == '0 && five_rate == '0 && fifteen_rate == '0)
        else $error("Nonzero rate before the first interval.");

endmodule

bind ewma_event_rate_meter eerm_checker u_eerm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (rates.valid),
    .out_ready    (rates.ready),
    .one_rate     (rates.one_minute_rate),
    .five_rate    (rates.five_minute_rate),
    .fifteen_rate (rates.fifteen_minute_rate),
    .rates_valid  (rates.rates_valid)
);
